>>> rtl/core/tlwc_pkg.sv
// Shared types and constants for the text line, word and column counter.
// Depends on nothing; used by tlwc_count and text_line_word_column_counter_top.
package tlwc_pkg;

    // Default parameter values
    localparam int COUNT_BITS_DEF = 48;
    localparam int TAB_BITS_DEF   = 8;

    // Fixed field widths
    localparam int OUT_BITS   = 48;
    localparam int TALLY_BITS = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Character codes
    localparam logic [7:0] CHAR_NL  = 8'h0A;
    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_SP  = 8'h20;

    // Request action codes
    localparam logic ACT_DATA = 1'b0;
    localparam logic ACT_EOF  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TAB_SIZE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_MODE = 1'b1;

    // Configuration reset values
    localparam logic [7:0] TAB_SIZE_RST    = 8'd1;
    localparam logic       COLUMN_MODE_RST = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } t_req;

    typedef struct packed {
        logic [OUT_BITS-1:0]   line_count;
        logic [OUT_BITS-1:0]   word_count;
        logic [OUT_BITS-1:0]   char_count;
        logic [OUT_BITS-1:0]   longest_line;
        logic [OUT_BITS-1:0]   total_lines;
        logic [OUT_BITS-1:0]   total_words;
        logic [OUT_BITS-1:0]   total_chars;
        logic [OUT_BITS-1:0]   total_longest;
        logic [TALLY_BITS-1:0] files_done;
    } t_res;

    typedef struct packed {
        logic [7:0] tab_size;
        logic       column_mode;
    } t_cfg;

endpackage

>>> rtl/core/tlwc_count.sv
// Counter state and per-request update for the text line, word and column counter.
// Depends on tlwc_pkg (t_req, t_res, t_cfg, character and action codes).
module tlwc_count #(
    parameter int COUNT_BITS = tlwc_pkg::COUNT_BITS_DEF,
    parameter int TAB_BITS   = tlwc_pkg::TAB_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  tlwc_pkg::t_req i_req,
    input  tlwc_pkg::t_cfg i_cfg,
    output tlwc_pkg::t_res o_res
);

    localparam int CW = COUNT_BITS;
    localparam int TW = TAB_BITS;
    localparam int OW = tlwc_pkg::OUT_BITS;
    localparam int FW = tlwc_pkg::TALLY_BITS;

    logic [CW-1:0] r_column,  n_column;
    logic [TW-1:0] r_phase,   n_phase;
    logic          r_in_word, n_in_word;
    logic [CW-1:0] r_lines,   n_lines;
    logic [CW-1:0] r_words,   n_words;
    logic [CW-1:0] r_chars,   n_chars;
    logic [CW-1:0] r_longest, n_longest;
    logic [CW-1:0] r_sum_lines,   n_sum_lines;
    logic [CW-1:0] r_sum_words,   n_sum_words;
    logic [CW-1:0] r_sum_chars,   n_sum_chars;
    logic [CW-1:0] r_sum_longest, n_sum_longest;
    logic [FW-1:0] r_tally,   n_tally;

    logic [TW-1:0] w_tab_raw;
    logic [TW-1:0] w_tab;
    logic [TW-1:0] w_adv;
    logic [TW:0]   w_phase_inc;
    logic [TW-1:0] w_phase_next;
    logic          w_nl;
    logic          w_tab_char;
    logic          w_white;
    logic [CW-1:0] w_eof_chars;
    logic [CW-1:0] w_eof_longest;

    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CW] ? {CW{1'b1}} : s[CW-1:0];
    endfunction

    // a + b + 1, clamped; fits in CW+1 bits since both operands are at most all ones
    function automatic logic [CW-1:0] sat_add_inc(input logic [CW-1:0] a,
                                                  input logic [CW-1:0] b);
        logic [CW:0] s;
        s = {1'b0, a} + {1'b0, b} + {{CW{1'b0}}, 1'b1};
        return s[CW] ? {CW{1'b1}} : s[CW-1:0];
    endfunction

    // Tab size masked to the phase width; zero acts as one
    assign w_tab_raw = TW'(i_cfg.tab_size);
    assign w_tab     = (w_tab_raw == '0) ? TW'(1) : w_tab_raw;

    assign w_adv        = (r_phase < w_tab) ? (w_tab - r_phase) : w_tab;
    assign w_phase_inc  = {1'b0, r_phase} + (TW+1)'(1);
    assign w_phase_next = (r_phase >= w_tab || w_phase_inc >= {1'b0, w_tab})
                          ? '0 : w_phase_inc[TW-1:0];

    assign w_nl       = (i_req.data_byte == tlwc_pkg::CHAR_NL);
    assign w_tab_char = (i_req.data_byte == tlwc_pkg::CHAR_TAB);
    assign w_white    = w_nl || w_tab_char || (i_req.data_byte == tlwc_pkg::CHAR_SP);

    assign w_eof_chars   = sat_add(r_chars, r_column);
    assign w_eof_longest = (r_column > r_longest) ? r_column : r_longest;

    always_comb begin
        n_column      = r_column;
        n_phase       = r_phase;
        n_in_word     = r_in_word;
        n_lines       = r_lines;
        n_words       = r_words;
        n_chars       = r_chars;
        n_longest     = r_longest;
        n_sum_lines   = r_sum_lines;
        n_sum_words   = r_sum_words;
        n_sum_chars   = r_sum_chars;
        n_sum_longest = r_sum_longest;
        n_tally       = r_tally;

        if (i_step) begin
            if (i_req.action == tlwc_pkg::ACT_DATA) begin
                if (i_cfg.column_mode) begin
                    if (w_nl) begin
                        n_longest = w_eof_longest;
                        n_chars   = sat_add_inc(r_chars, r_column);
                        n_lines   = sat_add(r_lines, CW'(1));
                        n_column  = '0;
                        n_phase   = '0;
                    end else if (w_tab_char) begin
                        n_column = sat_add(r_column, CW'(w_adv));
                        n_phase  = '0;
                    end else begin
                        n_column = sat_add(r_column, CW'(1));
                        n_phase  = w_phase_next;
                    end
                    if (w_white) begin
                        if (r_in_word) begin
                            n_words = sat_add(r_words, CW'(1));
                        end
                        n_in_word = 1'b0;
                    end else begin
                        n_in_word = 1'b1;
                    end
                end else begin
                    if (w_nl) begin
                        n_lines = sat_add(r_lines, CW'(1));
                    end
                    n_chars = sat_add(r_chars, CW'(1));
                end
            end else begin
                n_sum_lines   = sat_add(r_sum_lines, r_lines);
                n_sum_words   = sat_add(r_sum_words, r_words);
                n_sum_chars   = sat_add(r_sum_chars, w_eof_chars);
                n_sum_longest = (w_eof_longest > r_sum_longest) ? w_eof_longest
                                                                : r_sum_longest;
                n_tally       = (r_tally == {FW{1'b1}}) ? r_tally : r_tally + FW'(1);
                // Clear per-file state; an open word is dropped
                n_column  = '0;
                n_phase   = '0;
                n_in_word = 1'b0;
                n_lines   = '0;
                n_words   = '0;
                n_chars   = '0;
                n_longest = '0;
            end
        end
    end

    // Result of an end-of-file request, valid in the cycle it steps
    always_comb begin
        o_res.line_count    = OW'(r_lines);
        o_res.word_count    = OW'(r_words);
        o_res.char_count    = OW'(w_eof_chars);
        o_res.longest_line  = OW'(w_eof_longest);
        o_res.total_lines   = OW'(n_sum_lines);
        o_res.total_words   = OW'(n_sum_words);
        o_res.total_chars   = OW'(n_sum_chars);
        o_res.total_longest = OW'(n_sum_longest);
        o_res.files_done    = n_tally;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column      <= '0;
            r_phase       <= '0;
            r_in_word     <= 1'b0;
            r_lines       <= '0;
            r_words       <= '0;
            r_chars       <= '0;
            r_longest     <= '0;
            r_sum_lines   <= '0;
            r_sum_words   <= '0;
            r_sum_chars   <= '0;
            r_sum_longest <= '0;
            r_tally       <= '0;
        end else begin
            r_column      <= n_column;
            r_phase       <= n_phase;
            r_in_word     <= n_in_word;
            r_lines       <= n_lines;
            r_words       <= n_words;
            r_chars       <= n_chars;
            r_longest     <= n_longest;
            r_sum_lines   <= n_sum_lines;
            r_sum_words   <= n_sum_words;
            r_sum_chars   <= n_sum_chars;
            r_sum_longest <= n_sum_longest;
            r_tally       <= n_tally;
        end
    end

endmodule

>>> rtl/core/text_line_word_column_counter_top.sv
// Top level of the text line, word and column counter.
// Depends on tlwc_pkg and tlwc_count.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_req) carries one request per
//   accepted cycle: a text byte (action data) or an end-of-file marker.
//   Output channel (o_out_valid / i_out_ready / o_out_res) carries one result
//   per end-of-file request: per-file line, word, column and longest-line
//   counts, running totals and the number of files finished.
//   Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
//   (tab size, column mode) at the clock edge; write only while idle.
// Timing:
//   One request per cycle, but for the end-of-file wait below. A request is held in the input
//   register while the counter update runs in one pass; an end-of-file result
//   is captured in the result register when its request steps.
//   The result register holds a finished result while the input side keeps
//   taking data bytes; only an end-of-file request meeting a stalled, full
//   result register waits, and then the input side holds as well.
// Reset:
//   Synchronous, active low. Clears all counters and totals, empties both
//   registers, and loads tab size 1 and full column mode.
module text_line_word_column_counter_top #(
    parameter int COUNT_BITS = tlwc_pkg::COUNT_BITS_DEF,
    parameter int TAB_BITS   = tlwc_pkg::TAB_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  tlwc_pkg::t_req                     i_in_req,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output tlwc_pkg::t_res                     o_out_res,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [tlwc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tlwc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic           r_in_valid;
    tlwc_pkg::t_req r_in;
    logic           r_out_valid;
    tlwc_pkg::t_res r_out;
    tlwc_pkg::t_cfg r_cfg;

    tlwc_pkg::t_res w_res;
    logic           w_out_free;
    logic           w_step;
    logic           w_eof_step;

    // The result register can take a new result if empty or being drained
    assign w_out_free = !r_out_valid || i_out_ready;
    // Data bytes always advance; an end-of-file needs room for its result
    assign w_step     = r_in_valid && (r_in.action == tlwc_pkg::ACT_DATA || w_out_free);
    assign w_eof_step = w_step && (r_in.action == tlwc_pkg::ACT_EOF);
    assign o_in_ready = !r_in_valid || w_step;

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tab_size    <= tlwc_pkg::TAB_SIZE_RST;
            r_cfg.column_mode <= tlwc_pkg::COLUMN_MODE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tlwc_pkg::REG_TAB_SIZE:    r_cfg.tab_size    <= i_cfg_data;
                tlwc_pkg::REG_COLUMN_MODE: r_cfg.column_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input register: load whenever the held request moves on or none is held
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_req;
        end
    end

    tlwc_count #(
        .COUNT_BITS (COUNT_BITS),
        .TAB_BITS   (TAB_BITS)
    ) u_count (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_req   (r_in),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    // Result register: capture on end of file, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_eof_step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_eof_step) begin
            r_out <= w_res;
        end
    end

    // A new result appears only after an end-of-file request stepped
    a_out_from_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_eof_step))
        else $error("result appeared without an end-of-file request");

    // Input side only stalls behind a pending end of file and a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_in.action == tlwc_pkg::ACT_EOF
                         && r_out_valid && !i_out_ready))
        else $error("input stalled without cause");

    // Every result counts at least one finished file
    a_files_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_eof_step |=> (r_out_valid && r_out.files_done != '0))
        else $error("result missing or file count zero");

endmodule
